FILE: rtl/core/g2g_pkg.sv
// Package for the go-to-goal controller: field widths, register indexes,
// CORDIC arctangent table and fixed angle constants. No dependencies.
`default_nettype none
package g2g_pkg;

  localparam int unsigned PosW = 16;
  localparam int unsigned HdW = 15;
  localparam int unsigned GainW = 12;
  localparam int unsigned ThrW = 12;
  localparam int unsigned CmdW = 18;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegGoalX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGoalY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAngGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLinGain = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThresh = 3'd4;

  localparam logic signed [29:0] HalfPiQ24 = 30'sd26353589;
  localparam logic signed [19:0] PiQ12 = 20'sd12868;
  localparam logic signed [19:0] TwoPiQ12 = 20'sd25736;

  function automatic logic signed [29:0] atan_q24(input logic [4:0] i);
    logic signed [29:0] r;
    case (i)
      5'd0: r = 30'sd13176795;
      5'd1: r = 30'sd7778716;
      5'd2: r = 30'sd4110060;
      5'd3: r = 30'sd2086331;
      5'd4: r = 30'sd1047214;
      5'd5: r = 30'sd524117;
      5'd6: r = 30'sd262123;
      5'd7: r = 30'sd131069;
      5'd8: r = 30'sd65536;
      5'd9: r = 30'sd32768;
      5'd10: r = 30'sd16384;
      5'd11: r = 30'sd8192;
      5'd12: r = 30'sd4096;
      5'd13: r = 30'sd2048;
      5'd14: r = 30'sd1024;
      5'd15: r = 30'sd512;
      5'd16: r = 30'sd256;
      5'd17: r = 30'sd128;
      5'd18: r = 30'sd64;
      5'd19: r = 30'sd32;
      5'd20: r = 30'sd16;
      5'd21: r = 30'sd8;
      5'd22: r = 30'sd4;
      5'd23: r = 30'sd2;
      default: r = 30'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/go_to_goal_controller_unit.sv
// Top level of the go-to-goal controller: config registers and the
// pipeline. Depends on g2g_pkg.
//
// One pose request enters per cycle unless the output stalls. The CORDIC
// vectoring iterations and the 17 square root bit stages run side by side
// in one shared stage chain, padded to the longer of the two, and the
// offset, pre-rotation, wrap and gain stages complete the pipeline. The
// whole pipeline advances only when the output register is free or being
// taken.
`default_nettype none
module go_to_goal_controller_unit import g2g_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // position_x [15:0], position_y [31:16], heading [46:32], zero fill
  input  wire logic [47:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // angular_cmd [17:0], linear_cmd [35:18], arrived [36], zero fill
  output      logic [39:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned NC = CORDIC_STAGES;
  localparam int unsigned NS = 17;     // square root result bits
  localparam int unsigned ZW = 30;
  localparam int unsigned XW = 28;     // cordic x/y width

  logic [PosW-1:0] goal_x_q, goal_y_q;
  logic [GainW-1:0] ang_gain_q, lin_gain_q;
  logic [ThrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      ang_gain_q <= 12'd768;
      lin_gain_q <= 12'd256;
      thr_q <= 12'd205;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGoalX: goal_x_q <= cfg_data_i;
        RegGoalY: goal_y_q <= cfg_data_i;
        RegAngGain: ang_gain_q <= cfg_data_i[GainW-1:0];
        RegLinGain: lin_gain_q <= cfg_data_i[GainW-1:0];
        RegThresh: thr_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 0: offsets, squared distance, arrival compare.
  logic v0_q, arr0_q, zero0_q;
  logic signed [16:0] dx0_q, dy0_q;
  logic signed [HdW-1:0] hd0_q;
  logic [33:0] d2_0_q;
  logic signed [16:0] dx_c, dy_c;
  logic signed [33:0] dxsq_c, dysq_c;
  assign dx_c = $signed({1'b0, goal_x_q}) - $signed({1'b0, s_axis_tdata[15:0]});
  assign dy_c = $signed({1'b0, goal_y_q}) - $signed({1'b0, s_axis_tdata[31:16]});
  assign dxsq_c = dx_c * dx_c;
  assign dysq_c = dy_c * dy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx0_q <= dx_c;
      dy0_q <= dy_c;
      hd0_q <= s_axis_tdata[46:32];
      zero0_q <= (dx_c == '0) && (dy_c == '0);
      d2_0_q <= unsigned'(dxsq_c) + unsigned'(dysq_c);
    end
  end
  // arrival compared on stage 0 output with current threshold
  always_comb arr0_q = (d2_0_q < (34'(thr_q) * 34'(thr_q)));

  // CORDIC stages, square root stages run alongside, padded to equal length.
  localparam int unsigned NP = (NC > NS) ? NC : NS;
  logic signed [XW-1:0] cx_q [NP+1];
  logic signed [XW-1:0] cy_q [NP+1];
  logic signed [ZW-1:0] cz_q [NP+1];
  logic [33:0] rem_q [NP+1];
  logic [16:0] root_q [NP+1];
  logic cv_q [NP+1];
  logic carr_q [NP+1];
  logic czero_q [NP+1];
  logic signed [HdW-1:0] chd_q [NP+1];

  // Stage 1: quadrant pre-rotation into the first CORDIC register.
  logic signed [XW-1:0] sx, sy;
  assign sx = XW'(dx0_q) <<< 8;
  assign sy = XW'(dy0_q) <<< 8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q[0] <= 1'b0;
    else if (adv) cv_q[0] <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      carr_q[0] <= arr0_q;
      czero_q[0] <= zero0_q;
      chd_q[0] <= hd0_q;
      rem_q[0] <= d2_0_q;
      root_q[0] <= '0;
      if (sx < 0) begin
        if (sy >= 0) begin
          cx_q[0] <= sy; cy_q[0] <= -sx; cz_q[0] <= HalfPiQ24;
        end else begin
          cx_q[0] <= -sy; cy_q[0] <= sx; cz_q[0] <= -HalfPiQ24;
        end
      end else begin
        cx_q[0] <= sx; cy_q[0] <= sy; cz_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NP; i++) begin : g_it
    logic signed [XW-1:0] ys, xs;
    logic [33:0] trial;
    logic [16:0] rt;
    assign ys = cy_q[i] >>> i;
    assign xs = cx_q[i] >>> i;
    assign rt = root_q[i] | (17'd1 << (NS-1-((i < NS) ? i : 0)));
    assign trial = 34'(rt) * 34'(rt);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i+1] <= 1'b0;
      else if (adv) cv_q[i+1] <= cv_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        carr_q[i+1] <= carr_q[i];
        czero_q[i+1] <= czero_q[i];
        chd_q[i+1] <= chd_q[i];
        rem_q[i+1] <= rem_q[i];
        if (i < NS && trial <= rem_q[i]) root_q[i+1] <= rt;
        else root_q[i+1] <= root_q[i];
        if (i >= NC) begin
          cx_q[i+1] <= cx_q[i]; cy_q[i+1] <= cy_q[i]; cz_q[i+1] <= cz_q[i];
        end else if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + atan_q24(5'(i));
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - atan_q24(5'(i));
        end
      end
    end
  end

  // Wrap stage.
  logic v2_q, arr2_q;
  logic signed [19:0] err2_q;
  logic [16:0] dist2_q;
  logic signed [ZW-1:0] zr;
  logic signed [19:0] brg, e0, e1, e2;
  assign zr = (cz_q[NP] + ZW'(2048)) >>> 12;
  assign brg = czero_q[NP] ? 20'sd0 : 20'(zr);
  assign e0 = brg - 20'(chd_q[NP]);
  assign e1 = (e0 > PiQ12) ? e0 - TwoPiQ12 : e0;
  assign e2 = (e1 < -PiQ12) ? e1 + TwoPiQ12 : e1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= cv_q[NP];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      arr2_q <= carr_q[NP];
      err2_q <= e2;
      dist2_q <= root_q[NP];
    end
  end

  // Gain and saturation into the output register.
  logic signed [33:0] ap, a8;
  logic [29:0] lp, l8;
  logic [CmdW-1:0] ang_c, lin_c;
  assign ap = 34'(err2_q) * $signed({22'd0, ang_gain_q}) + 34'sd128;
  assign a8 = ap >>> 8;
  assign ang_c = (a8 > 34'sd131071) ? 18'h1FFFF :
                 (a8 < -34'sd131072) ? 18'h20000 : a8[CmdW-1:0];
  assign lp = 30'(lin_gain_q) * 30'(dist2_q) + 30'd128;
  assign l8 = lp >> 8;
  assign lin_c = (l8 > 30'd262143) ? 18'h3FFFF : l8[CmdW-1:0];

  logic vo_q;
  logic [39:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (adv) vo_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (arr2_q) out_q <= {3'd0, 1'b1, 36'd0};
      else out_q <= {3'd0, 1'b0, lin_c, ang_c};
    end
  end
  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata = out_q;

endmodule
`default_nettype wire

FILE: sim/g2g_checker.sv
// Checker for the go-to-goal controller: mirrors the registers, computes the
// expected command for every accepted pose and compares it. Depends on g2g_pkg.
`timescale 1ns / 100ps
module g2g_checker import g2g_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic               arrived;
    logic [17:0]        linear;
    logic signed [17:0] angular;
  } command_t;

  logic [15:0] goal_x, goal_y;
  logic [11:0] ang_gain, lin_gain, threshold;
  command_t    cmd_queue[$];

  localparam longint AtanTbl[24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    r = 0;
    for (longint b = 64'd1 << 17; b > 0; b = b >> 1)
      if ((r + b) * (r + b) <= v) r = r + b;
    return r;
  endfunction

  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z, nx, ny;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    dx = dx * 256;
    dy = dy * 256;
    if (dx < 0) begin
      if (dy >= 0) begin
        x = dy; y = -dx; z = 26353589;
      end else begin
        x = -dy; y = dx; z = -26353589;
      end
    end else begin
      x = dx; y = dy;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (y > 0) begin
        nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += AtanTbl[i];
      end else begin
        nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= AtanTbl[i];
      end
      x = nx; y = ny;
    end
    return floor_shift(z + 2048, 12);
  endfunction

  function automatic command_t steer(logic [47:0] pose);
    longint dx, dy, d2, err, ang, lin;
    command_t c;
    dx = longint'(goal_x) - longint'(pose[15:0]);
    dy = longint'(goal_y) - longint'(pose[31:16]);
    d2 = dx * dx + dy * dy;
    c = '0;
    if (d2 < longint'(threshold) * longint'(threshold)) begin
      c.arrived = 1'b1;
      return c;
    end
    err = bearing(dx, dy) - longint'($signed(pose[46:32]));
    if (err > 12868) err -= 25736;
    if (err < -12868) err += 25736;
    ang = floor_shift(longint'(ang_gain) * err + 128, 8);
    if (ang > 131071) ang = 131071;
    if (ang < -131072) ang = -131072;
    lin = (longint'(lin_gain) * root_floor(d2) + 128) >>> 8;
    if (lin > 262143) lin = 262143;
    c.angular = ang[17:0];
    c.linear = lin[17:0];
    return c;
  endfunction

  assign pending_o = cmd_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x <= '0;
      goal_y <= '0;
      ang_gain <= 12'd768;
      lin_gain <= 12'd256;
      threshold <= 12'd205;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGoalX: goal_x <= cfg_data_i;
          RegGoalY: goal_y <= cfg_data_i;
          RegAngGain: ang_gain <= cfg_data_i[11:0];
          RegLinGain: lin_gain <= cfg_data_i[11:0];
          RegThresh: threshold <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) cmd_queue.push_back(steer(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        command_t got, want;
        got = m_axis_tdata[36:0];
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected command %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = cmd_queue.pop_front();
          if (got.angular !== want.angular || got.linear !== want.linear
              || got.arrived !== want.arrived) begin
            $display("%0t: expected ang %0d lin %0d arr %0b, got ang %0d lin %0d arr %0b",
                     $time, want.angular, want.linear, want.arrived,
                     got.angular, got.linear, got.arrived);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb_go_to_goal_controller_unit.sv
// Testbench top for the go-to-goal controller: drives poses and register writes
// under varying backpressure. Depends on g2g_pkg, g2g_checker and the RTL.
`timescale 1ns / 100ps
module tb_go_to_goal_controller_unit;
  import g2g_pkg::*;

  localparam int unsigned Latency = 17 + 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  int fail_count, pending;
  int send_idle, recv_idle;
  bit hold_off;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  go_to_goal_controller_unit dut (.*);

  g2g_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    hold_off = 1'b0;
    #1000000;
    $display("go_to_goal_controller_unit: mismatch");
    $finish;
  end

  task automatic send_pose(logic [15:0] px, logic [15:0] py, logic [14:0] hd);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, hd, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [14:0] rand_heading();
    int h;
    h = $urandom_range(4) == 0 ? $urandom_range(32767) : $urandom_range(25736) - 12868;
    return h[14:0];
  endfunction

  task automatic random_poses(int n);
    logic [15:0] gx, gy;
    gx = chk.goal_x;
    gy = chk.goal_y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_pose(gx + 16'($urandom_range(400)) - 16'd200,
                     gy + 16'($urandom_range(400)) - 16'd200, rand_heading());
        1: send_pose(gx + 16'($urandom_range(8)) - 16'd4, gy + 16'($urandom_range(8)) - 16'd4,
                     rand_heading());
        default: send_pose(16'($urandom), 16'($urandom), rand_heading());
      endcase
    end
  endtask

  initial begin
    send_idle = 34;
    recv_idle = 81;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pose(16'h0000, 16'h0000, 15'h0000);
    send_pose(16'hFFFF, 16'hFFFF, 15'd12868);
    send_pose(16'd100, 16'd0, -15'sd12868);
    send_pose(16'd0, 16'd100, 15'h3FFF);
    send_pose(16'hFFFF, 16'h0000, 15'h4000);
    send_pose(16'h0000, 16'hFFFF, 15'h7FFF);
    drain();
    write_reg(RegGoalX, 16'h8000);
    write_reg(RegGoalY, 16'h8000);
    write_reg(RegAngGain, 16'hFFFF);
    write_reg(RegLinGain, 16'h0FFF);
    write_reg(RegThresh, 16'h0000);
    write_reg(3'd7, 16'h1234);
    send_pose(16'h8000, 16'h8000, 15'd0);
    send_pose(16'h0000, 16'h0000, 15'd12868);
    send_pose(16'hFFFF, 16'h0000, -15'sd12868);
    send_pose(16'h0000, 16'hFFFF, 15'h3FFF);
    send_pose(16'hFFFF, 16'hFFFF, 15'h4000);
    send_pose(16'h7000, 16'h8000, 15'd0);
    send_pose(16'h9000, 16'h8000, 15'd0);
    send_pose(16'h8000, 16'h7000, 15'd0);
    drain();
    write_reg(RegThresh, 16'h0FFF);
    write_reg(RegAngGain, 16'd0);
    write_reg(RegLinGain, 16'd0);
    send_pose(16'h8FFE, 16'h8000, 15'd100);
    send_pose(16'h8FFF, 16'h8000, 15'd100);
    send_pose(16'h8000, 16'h8000, 15'd100);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle = 81; recv_idle = 34;
      end else if (phase == 6) begin
        send_idle = 0; recv_idle = 0;
      end
      write_reg(RegGoalX, 16'($urandom));
      write_reg(RegGoalY, 16'($urandom));
      write_reg(RegAngGain, phase == 4 ? 16'hFFF : 16'($urandom_range(4095)));
      write_reg(RegLinGain, phase == 5 ? 16'hFFF : 16'($urandom_range(4095)));
      write_reg(RegThresh, phase == 2 ? 16'd0 : 16'($urandom_range(4095)));
      if (phase == 7) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
          random_poses(80);
        join
      end
      random_poses(180);
      drain();
    end

    if (fail_count == 0) begin
      $display("go_to_goal_controller_unit: match");
    end else begin
      $display("go_to_goal_controller_unit: mismatch");
    end
    $finish;
  end

endmodule
